// File: design/srr_pkg.sv
// Shared types and constants for the selective-repeat receiver.
// Depends on nothing; every other design file imports it.
`timescale 1ns / 1ps
`default_nettype none

package srr_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned WIN_W  = 6;

  localparam logic [WIN_W-1:0]  WIN_RESET   = 6'd16;
  localparam logic [DATA_W-1:0] FINAL_RESET = 32'hFFFF_FFFF;

  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_DLV = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BOUND,
    ST_CLASS,
    ST_REDUCE,
    ST_STORE,
    ST_SCAN,
    ST_PRED,
    ST_ACK,
    ST_RD,
    ST_DLV
  } srr_state_t;

  typedef struct packed {
    logic wr;
    logic rd;
    logic clr;
  } srr_store_cmd_t;

  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] seq;
    logic [DATA_W-1:0] data;
    logic              finished;
    logic              last;
  } srr_result_t;

endpackage

`default_nettype wire

// File: design/srr_slot_store.sv
// Slot store: payload memory with registered read, valid bits and fill count.
// Depends on srr_pkg for the command struct and data width.
`timescale 1ns / 1ps
`default_nettype none

module srr_slot_store
  import srr_pkg::*;
#(
  parameter int unsigned DEPTH  = 63,
  parameter int unsigned ADDR_W = 6,
  parameter int unsigned CNT_W  = 6
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire srr_store_cmd_t    cmd,
  input  wire logic [ADDR_W-1:0] q_addr,
  input  wire logic [ADDR_W-1:0] base_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  output logic                   q_valid,
  output logic [DATA_W-1:0]      rd_data,
  output logic [CNT_W-1:0]       count
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[q_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data <= mem[base_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else begin
      if (cmd.wr) begin
        valid[q_addr] <= 1'b1;
      end
      if (cmd.clr) begin
        valid[base_addr] <= 1'b0;
      end
      if (cmd.wr && !cmd.clr) begin
        count <= count + CNT_W'(1);
      end else if (cmd.clr && !cmd.wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assign q_valid = valid[q_addr];

endmodule

`default_nettype wire

// File: design/srr_out_stage.sv
// Output register for result words on the master stream side.
// Depends on srr_pkg for the result struct.
`timescale 1ns / 1ps
`default_nettype none

module srr_out_stage
  import srr_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire srr_result_t   res,
  output logic               free,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [63:0]        m_tdata,  // seq_out, data_out
  output logic [1:0]         m_tuser,  // kind, finished
  output logic               m_tlast
);

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {res.data, res.seq};
      m_tuser <= {res.finished, res.kind};
      m_tlast <= res.last;
    end
  end

endmodule

`default_nettype wire

// File: design/selective_repeat_receiver.sv
// Selective-repeat receiver top level: packet control sequencer around the slot store.
// Depends on srr_pkg, srr_slot_store and srr_out_stage.
`timescale 1ns / 1ps
`default_nettype none

// Takes one received packet per input word and answers with acknowledgement words and
// in-order delivery words; tlast marks the final word caused by a packet. One packet is
// handled at a time. For the default depth the slot index of a data packet inside the
// window needs at most one reduction step. The delivery run is bounded by the valid-bit
// scan and by the single read port of the payload memory, which reads each slot and
// delivers it before reading the next, plus any output stall. Payloads sit in slot seq
// mod WINDOW_MAX; valid bits are cleared by reset at once.
module selective_repeat_receiver
  import srr_pkg::*;
#(
  parameter int unsigned WINDOW_MAX = 63
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [WIN_W-1:0] cfg_wdata,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [63:0]      s_tdata,  // seq_no, payload
  input  wire logic             s_tuser,  // checksum_ok
  input  wire logic             s_tlast,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [63:0]           m_tdata,  // seq_out, data_out
  output logic [1:0]            m_tuser,  // kind, finished
  output logic                  m_tlast
);

  localparam int unsigned SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned LEN_W  = $clog2(WINDOW_MAX + 1);
  localparam int unsigned IDX_W  = $clog2(WINDOW_MAX + 64);

  srr_state_t state, state_next;

  logic [WIN_W-1:0]  window;
  logic [DATA_W-1:0] base;
  logic [SLOT_W-1:0] base_slot;
  logic              end_seen;
  logic [DATA_W-1:0] final_seq;

  logic [DATA_W-1:0] pkt_seq;
  logic [DATA_W-1:0] pkt_pay;
  logic              pkt_ok;
  logic              pkt_hdr;

  logic [DATA_W-1:0] lo;
  logic [DATA_W:0]   hi;
  logic              below;
  logic              done;
  logic [WIN_W-1:0]  diff;
  logic [IDX_W-1:0]  work_idx;
  logic [SLOT_W-1:0] scan_ptr;
  logic [LEN_W-1:0]  run_len;
  logic              ack_fin;
  logic              ack_last;

  srr_store_cmd_t    cmd;
  logic [SLOT_W-1:0] q_addr;
  logic              q_valid;
  logic [DATA_W-1:0] rd_data;
  logic [LEN_W-1:0]  vcount;

  logic              out_load;
  logic              out_free;
  srr_result_t       res;

  logic              in_acc;
  logic              store_ok;
  logic              scan_go;

  assign in_acc   = s_tvalid && s_tready;
  assign store_ok = !q_valid && ((WIN_W + 1)'(vcount) < (WIN_W + 1)'(window));
  assign scan_go  = q_valid && (run_len < LEN_W'(WINDOW_MAX));

  always_comb begin
    case (state)
      ST_SCAN: q_addr = scan_ptr;
      ST_RD,
      ST_DLV:  q_addr = base_slot;
      default: q_addr = work_idx[SLOT_W-1:0];
    endcase
  end

  srr_slot_store #(
    .DEPTH  (WINDOW_MAX),
    .ADDR_W (SLOT_W),
    .CNT_W  (LEN_W)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .q_addr    (q_addr),
    .base_addr (base_slot),
    .wr_data   (pkt_pay),
    .q_valid   (q_valid),
    .rd_data   (rd_data),
    .count     (vcount)
  );

  srr_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .res      (res),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    out_load   = 1'b0;
    res        = '0;
    case (state)
      ST_IDLE: begin
        s_tready = !rst;
        if (in_acc) begin
          state_next = ST_BOUND;
        end
      end
      ST_BOUND: begin
        state_next = ST_CLASS;
      end
      ST_CLASS: begin
        if (done || !pkt_ok) begin
          state_next = ST_IDLE;
        end else if (below) begin
          state_next = (pkt_seq >= lo) ? ST_ACK : ST_IDLE;
        end else if ({1'b0, pkt_seq} < hi) begin
          state_next = pkt_hdr ? ST_ACK : ST_REDUCE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_REDUCE: begin
        if (work_idx < IDX_W'(WINDOW_MAX)) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.wr     = store_ok;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!scan_go) begin
          state_next = ST_PRED;
        end
      end
      ST_PRED: begin
        state_next = ST_ACK;
      end
      ST_ACK: begin
        res.kind     = KIND_ACK;
        res.seq      = pkt_seq;
        res.data     = '0;
        res.finished = ack_fin;
        res.last     = ack_last;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ack_last ? ST_IDLE : ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_DLV;
      end
      ST_DLV: begin
        res.kind     = KIND_DLV;
        res.seq      = base;
        res.data     = rd_data;
        res.finished = ack_fin;
        res.last     = (run_len == LEN_W'(1));
        if (out_free) begin
          out_load   = 1'b1;
          cmd.clr    = 1'b1;
          state_next = (run_len == LEN_W'(1)) ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= WIN_RESET;
    end else if (cfg_we) begin
      window    <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base      <= '0;
      base_slot <= '0;
      end_seen  <= 1'b0;
      final_seq <= FINAL_RESET;
    end else begin
      if (state == ST_CLASS && !done && pkt_ok && !below && ({1'b0, pkt_seq} < hi) &&
          pkt_hdr) begin
        end_seen  <= 1'b1;
        final_seq <= pkt_seq;
      end
      if (state == ST_DLV && out_free) begin
        base      <= base + DATA_W'(1);
        base_slot <= (base_slot == SLOT_W'(WINDOW_MAX - 1)) ? '0 : base_slot + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          pkt_seq <= s_tdata[31:0];
          pkt_pay <= s_tdata[63:32];
          pkt_ok  <= s_tuser;
          pkt_hdr <= s_tlast;
        end
      end
      ST_BOUND: begin
        lo    <= (base > DATA_W'(window)) ? base - DATA_W'(window) : '0;
        hi    <= {1'b0, base} + (DATA_W + 1)'(window);
        below <= pkt_seq < base;
        done  <= end_seen && (base == final_seq);
        diff  <= pkt_seq[WIN_W-1:0] - base[WIN_W-1:0];
      end
      ST_CLASS: begin
        work_idx <= IDX_W'(base_slot) + IDX_W'(diff);
        run_len  <= '0;
        ack_last <= 1'b1;
        ack_fin  <= below ? 1'b0 : (base == pkt_seq);
      end
      ST_REDUCE: begin
        if (work_idx >= IDX_W'(WINDOW_MAX)) begin
          work_idx <= work_idx - IDX_W'(WINDOW_MAX);
        end
      end
      ST_STORE: begin
        scan_ptr <= base_slot;
      end
      ST_SCAN: begin
        if (scan_go) begin
          run_len  <= run_len + LEN_W'(1);
          scan_ptr <= (scan_ptr == SLOT_W'(WINDOW_MAX - 1)) ? '0 : scan_ptr + SLOT_W'(1);
        end
      end
      ST_PRED: begin
        ack_fin  <= end_seen && ((base + DATA_W'(run_len)) == final_seq);
        ack_last <= (run_len == '0);
      end
      ST_DLV: begin
        if (out_free) begin
          run_len <= run_len - LEN_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    base_slot < SLOT_W'(WINDOW_MAX))
    else $error("Base slot index left the slot store.");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    vcount <= LEN_W'(WINDOW_MAX))
    else $error("Slot fill count exceeds the store depth.");

  a_dlv_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DLV) |-> q_valid)
    else $error("Delivery from a slot that holds no payload.");

  a_drop_quiet: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !s_tuser) |=> ##2 (state == ST_IDLE && !out_load))
    else $error("Packet with a bad checksum produced work.");

endmodule

`default_nettype wire
